// ----- rtl/lbvd_pkg.sv -----
// shared types and constants for the label bit vote downsampler
`timescale 1ns / 1ps
`default_nettype none
package lbvd_pkg;

  localparam int LABEL_W   = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = 11;
  localparam int POS_W     = 10;
  localparam int THR_W     = 5;
  localparam int DIM_MAX   = 1024;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_THRESHOLD = 2'd3;

  localparam logic [CFG_W-1:0] RST_INPUT_WIDTH    = 11'd256;
  localparam logic [CFG_W-1:0] RST_INPUT_HEIGHT   = 11'd256;
  localparam logic [THR_W-1:0] RST_FULL_THRESHOLD = 5'd16;
  localparam logic [THR_W-1:0] RST_ITEM_THRESHOLD = 5'd10;

  // label bits that vote against the item threshold
  localparam logic [LABEL_W-1:0] ITEM_BIT_MASK = 8'h30;

  typedef struct packed {
    logic [LABEL_W-1:0] label_pixel;
    logic               frame_start;
  } pixel_word_t;

  typedef struct packed {
    logic [LABEL_W-1:0] tile_label;
    logic               tile_valid;
    logic               frame_end;
  } tile_word_t;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic fresh_row;
    logic emit;
    logic frame_end;
  } pos_info_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_emit;
  } vote_status_t;

endpackage
`default_nettype wire

// ----- rtl/lbvd_pixel_if.sv -----
// handshake channel carrying one label subpixel word
`timescale 1ns / 1ps
`default_nettype none
interface lbvd_pixel_if;
  logic                      valid;
  logic                      ready;
  lbvd_pkg::pixel_word_t     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lbvd_tile_if.sv -----
// handshake channel carrying one tile vote word
`timescale 1ns / 1ps
`default_nettype none
interface lbvd_tile_if;
  logic                   valid;
  logic                   ready;
  lbvd_pkg::tile_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lbvd_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lbvd_ram #(
  parameter int WIDTH  = 40,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lbvd_position.sv -----
// raster position counters and per-subpixel tile flags
`timescale 1ns / 1ps
`default_nettype none
module lbvd_position #(
  parameter int TILE_LOG2     = 2,
  parameter int MAX_OUT_WIDTH = 256,
  parameter int ADDR_W        = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          frame_start,
  input  logic [lbvd_pkg::DIM_W-1:0]    input_width,
  input  logic [lbvd_pkg::DIM_W-1:0]    input_height,
  output lbvd_pkg::pos_info_t           info,
  output logic [ADDR_W-1:0]             tile_col
);
  import lbvd_pkg::*;

  localparam int TILE     = 1 << TILE_LOG2;
  localparam int WCAP_RAW = MAX_OUT_WIDTH * TILE;
  localparam int WCAP     = (WCAP_RAW > DIM_MAX) ? DIM_MAX : WCAP_RAW;

  localparam logic [DIM_W-1:0] TILE_D  = DIM_W'(TILE);
  localparam logic [DIM_W-1:0] TMASK_D = DIM_W'(TILE - 1);
  localparam logic [DIM_W-1:0] WCAP_D  = DIM_W'(WCAP);
  localparam logic [DIM_W-1:0] HCAP_D  = DIM_W'(DIM_MAX);
  localparam logic [POS_W-1:0] TMASK_P = POS_W'(TILE - 1);
  localparam logic [POS_W-1:0] LAST_TC = POS_W'(MAX_OUT_WIDTH - 1);

  function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] r;
    r = v & ~TMASK_D;
    if (r < TILE_D) begin
      r = TILE_D;
    end
    if (r > cap) begin
      r = cap & ~TMASK_D;
    end
    return r;
  endfunction

  logic [POS_W-1:0] col, row;
  logic [POS_W-1:0] col_next, row_next;
  logic [POS_W-1:0] col_s, row_s, col_e, row_e, tc_full;
  logic [DIM_W-1:0] w, h, col_inc, row_inc;

  assign w = fit_dim(input_width, WCAP_D);
  assign h = fit_dim(input_height, HCAP_D);

  always_comb begin
    col_s = frame_start ? '0 : col;
    row_s = frame_start ? '0 : row;
    // a shrunk geometry sends a stray counter back to zero
    col_e = ({1'b0, col_s} >= w) ? '0 : col_s;
    row_e = ({1'b0, row_s} >= h) ? '0 : row_s;

    col_inc = {1'b0, col_e} + DIM_W'(1);
    row_inc = {1'b0, row_e} + DIM_W'(1);
    if (col_inc >= w) begin
      col_next = '0;
      row_next = (row_inc >= h) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_next = col_inc[POS_W-1:0];
      row_next = row_e;
    end
  end

  always_comb begin
    info.first_col = (col_e & TMASK_P) == '0;
    info.last_col  = (col_e & TMASK_P) == TMASK_P;
    info.fresh_row = (row_e & TMASK_P) == '0;
    info.emit      = ((row_e & TMASK_P) == TMASK_P) && info.last_col;
    info.frame_end = ({1'b0, row_e} == h - DIM_W'(1)) &&
                     ({1'b0, col_e} == w - DIM_W'(1));
    tc_full  = col_e >> TILE_LOG2;
    tile_col = (tc_full > LAST_TC) ? ADDR_W'(LAST_TC) : ADDR_W'(tc_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lbvd_vote.sv -----
// per-bit tile counting, column count store and threshold vote
`timescale 1ns / 1ps
`default_nettype none
module lbvd_vote #(
  parameter int TILE_LOG2     = 2,
  parameter int MAX_OUT_WIDTH = 256,
  parameter int ADDR_W        = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lbvd_pkg::LABEL_W-1:0]    label_pixel,
  input  lbvd_pkg::pos_info_t             info,
  input  logic [ADDR_W-1:0]               tile_col,
  input  logic [lbvd_pkg::THR_W-1:0]      full_threshold,
  input  logic [lbvd_pkg::THR_W-1:0]      item_threshold,
  lbvd_tile_if.source                     tiles,
  output lbvd_pkg::vote_status_t          status
);
  import lbvd_pkg::*;

  // a count reaches tile_size squared at most
  localparam int CW    = 2 * TILE_LOG2 + 1;
  localparam int CMP_W = (CW > THR_W) ? CW : THR_W;

  logic                            s1_valid;
  logic [LABEL_W-1:0]              s1_pix;
  pos_info_t                       s1_info;
  logic [ADDR_W-1:0]               s1_tc;
  logic [LABEL_W-1:0][CW-1:0]      acc, acc_next, total, stored;
  logic [LABEL_W-1:0][THR_W-1:0]   thr;
  logic [LABEL_W-1:0]              label;
  logic                            o_valid;
  tile_word_t                      o_word;
  logic                            out_free, fire;
  logic                            seg_fresh, fresh_seg;

  assign out_free = !o_valid || tiles.ready;
  assign fire     = s1_valid && (!s1_info.emit || out_free);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pix  <= label_pixel;
      s1_info <= info;
      s1_tc   <= tile_col;
    end
  end

  // stored counts are fetched at the first column of a tile row and
  // used at its last column, so the write of the row above lands first
  lbvd_ram #(
    .WIDTH  (LABEL_W * CW),
    .DEPTH  (MAX_OUT_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_count_ram (
    .clk   (clk),
    .we    (fire && s1_info.last_col),
    .waddr (s1_tc),
    .wdata (total),
    .re    (fire && s1_info.first_col),
    .raddr (s1_tc),
    .rdata (stored)
  );

  // a tile row that carries on after a height wrap keeps the base it began with
  assign fresh_seg = s1_info.first_col ? s1_info.fresh_row : seg_fresh;

  always_comb begin
    for (int b = 0; b < LABEL_W; b++) begin
      acc_next[b] = (s1_info.first_col ? '0 : acc[b]) + CW'(s1_pix[b]);
      total[b]    = acc_next[b] + (fresh_seg ? '0 : stored[b]);
      thr[b]      = ITEM_BIT_MASK[b] ? item_threshold : full_threshold;
      label[b]    = CMP_W'(total[b]) >= CMP_W'(thr[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc       <= acc_next;
      seg_fresh <= fresh_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire && s1_info.emit) begin
      o_valid <= 1'b1;
    end else if (tiles.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_info.emit) begin
      o_word.tile_label <= label;
      o_word.tile_valid <= |label;
      o_word.frame_end  <= s1_info.frame_end;
    end
  end

  assign tiles.valid     = o_valid;
  assign tiles.data      = o_word;
  assign status.s1_valid = s1_valid;
  assign status.s1_emit  = s1_info.emit;

endmodule
`default_nettype wire

// ----- rtl/label_bit_vote_downsample.sv -----
// top level of the per-bit 4x4 label vote downsampler
//
//   channel   dir   payload                               handshake
//   pixels    in    label_pixel[7:0], frame_start         valid / ready
//   tiles     out   tile_label[7:0], tile_valid, frame_end valid / ready
//   cfg       in    cfg_index[1:0], cfg_data[10:0]        cfg_write
//
// one subpixel per clock while pixels.ready is high; a tile's last subpixel
// is held in the stage register, then its tile word in the output register
// the column count ram is read at a tile row's first column and written at
// its last, one port each, so it never limits the rate
// reset zeroes the position counters and loads register defaults; the
// count ram is not cleared and needs no pass
// pixels.ready drops only while a tile-closing word waits on a full,
// untaken output register
`timescale 1ns / 1ps
`default_nettype none
module label_bit_vote_downsample #(
  parameter int TILE_LOG2     = 2,
  parameter int MAX_OUT_WIDTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lbvd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbvd_pkg::CFG_W-1:0]       cfg_data,
  lbvd_pixel_if.sink                       pixels,
  lbvd_tile_if.source                      tiles
);
  import lbvd_pkg::*;

  localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  logic [DIM_W-1:0]  input_width, input_height;
  logic [THR_W-1:0]  full_threshold, item_threshold;
  pos_info_t         info;
  logic [ADDR_W-1:0] tile_col;
  vote_status_t      status;
  logic              in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_width    <= RST_INPUT_WIDTH;
      input_height   <= RST_INPUT_HEIGHT;
      full_threshold <= RST_FULL_THRESHOLD;
      item_threshold <= RST_ITEM_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_INPUT_WIDTH:    input_width    <= cfg_data;
        CFG_INPUT_HEIGHT:   input_height   <= cfg_data;
        CFG_FULL_THRESHOLD: full_threshold <= cfg_data[THR_W-1:0];
        CFG_ITEM_THRESHOLD: item_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  lbvd_position #(
    .TILE_LOG2     (TILE_LOG2),
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .accept       (pixels.valid && in_ready),
    .frame_start  (pixels.data.frame_start),
    .input_width  (input_width),
    .input_height (input_height),
    .info         (info),
    .tile_col     (tile_col)
  );

  lbvd_vote #(
    .TILE_LOG2     (TILE_LOG2),
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .ADDR_W        (ADDR_W)
  ) u_vote (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (pixels.valid),
    .in_ready       (in_ready),
    .label_pixel    (pixels.data.label_pixel),
    .info           (info),
    .tile_col       (tile_col),
    .full_threshold (full_threshold),
    .item_threshold (item_threshold),
    .tiles          (tiles),
    .status         (status)
  );

  assign pixels.ready = in_ready;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !status.s1_valid |-> pixels.ready)
    else $error("input stalled with an empty stage");

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    status.s1_valid && status.s1_emit && tiles.valid && !tiles.ready
    |-> !pixels.ready)
    else $error("tile word could be overwritten");

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (rst)
    status.s1_valid && status.s1_emit && !(tiles.valid && !tiles.ready)
    |=> tiles.valid)
    else $error("closed tile did not reach the output");

  a_flag_matches_label: assert property (@(posedge clk) disable iff (rst)
    tiles.valid |-> (tiles.data.tile_valid == (tiles.data.tile_label != '0)))
    else $error("tile_valid disagrees with tile_label");

endmodule
`default_nettype wire
